FILE: hdl/klb_pkg.sv
`timescale 1ns / 1ps

package klb_pkg;

    localparam int BUF_DEPTH_DEF  = 64;
    localparam int MAP_SIZE       = 128;
    localparam int KEY_W          = $clog2(MAP_SIZE);
    localparam int CMD_FIFO_DEPTH = 2;

    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;

    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_NONE = 2'd2;

    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] ch;
        logic [6:0] max_count;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_char;
        logic       dropped;
        logic       last;
    } result_t;

    function automatic logic [7:0] key_lookup(input logic [KEY_W-1:0] code);
        logic [7:0] ch;
        unique case (code)
            7'd2:    ch = "1";
            7'd3:    ch = "2";
            7'd4:    ch = "3";
            7'd5:    ch = "4";
            7'd6:    ch = "5";
            7'd7:    ch = "&";
            7'd8:    ch = "/";
            7'd9:    ch = "8";
            7'd10:   ch = "9";
            7'd11:   ch = "0";
            7'd14:   ch = CH_BACKSPACE;
            7'd15:   ch = CH_TAB;
            7'd16:   ch = "q";
            7'd17:   ch = "w";
            7'd18:   ch = "e";
            7'd19:   ch = "r";
            7'd20:   ch = "t";
            7'd21:   ch = "z";
            7'd22:   ch = "u";
            7'd23:   ch = "i";
            7'd24:   ch = "o";
            7'd25:   ch = "p";
            7'd27:   ch = "*";
            7'd28:   ch = CH_NEWLINE;
            7'd30:   ch = "a";
            7'd31:   ch = "s";
            7'd32:   ch = "d";
            7'd33:   ch = "f";
            7'd34:   ch = "g";
            7'd35:   ch = "h";
            7'd36:   ch = "j";
            7'd37:   ch = "k";
            7'd38:   ch = "l";
            7'd43:   ch = "#";
            7'd86:   ch = "<";
            7'd44:   ch = "y";
            7'd45:   ch = "x";
            7'd46:   ch = "c";
            7'd47:   ch = "v";
            7'd48:   ch = "b";
            7'd49:   ch = "n";
            7'd50:   ch = "m";
            7'd51:   ch = ",";
            7'd52:   ch = ".";
            7'd53:   ch = "-";
            7'd57:   ch = " ";
            default: ch = 8'd0;
        endcase
        return ch;
    endfunction

endpackage

FILE: hdl/klb_req_if.sv
`timescale 1ns / 1ps

interface klb_req_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] scancode;
    logic [7:0] delimiter;
    logic [6:0] max_count;

    modport source (output valid, output mode, output scancode, output delimiter,
                    output max_count, input ready);
    modport sink   (input valid, input mode, input scancode, input delimiter,
                    input max_count, output ready);
endinterface

FILE: hdl/klb_rsp_if.sv
`timescale 1ns / 1ps

interface klb_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [7:0] data_char;
    logic       dropped;
    logic       last;

    modport source (output valid, output result_kind, output data_char,
                    output dropped, output last, input ready);
    modport sink   (input valid, input result_kind, input data_char,
                    input dropped, input last, output ready);
endinterface

FILE: hdl/keyboard_line_buffer.sv
`timescale 1ns / 1ps
// Keyboard line buffer.
// req: one transaction per scancode (mode 0) or read request (mode 1).
//   Scancodes of 128 or more and unmapped codes give no result.
// rsp: echo of each typed character (with dropped set when the buffer is
//   full), a run of read characters ending with last, or one empty-end
//   result when a read finds no delimiter or would return no characters.
// Requests pass through a two-entry command queue; req.ready drops only
// while that queue is full.
// Order: an echo enters the output register once its command is at the head
// of the queue and that register is free. A read first scans the buffer
// memory, up to fill_count entries (one entry per cycle on its single read
// port), then reads and emits each returned character in turn, waiting on a
// stalled output, and last reads the next entry to drop a leading newline.
// Reset empties the buffer at once; buffer memory contents are not cleared.
// When rsp is stalled the result holds in its output register and the
// back end waits at its next result; the queue takes requests until full.
module keyboard_line_buffer #(
    parameter int BUF_DEPTH = klb_pkg::BUF_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    klb_req_if.sink   req,
    klb_rsp_if.source rsp
);
    import klb_pkg::*;

    localparam int CW = $clog2(BUF_DEPTH + 1);

    logic          fifo_push;
    logic          fifo_pop;
    logic          fifo_full;
    logic          fifo_empty;
    cmd_t          push_cmd;
    cmd_t          head_cmd;
    logic [CW-1:0] fill_count;

    klb_front u_front (
        .req  (req),
        .full (fifo_full),
        .push (fifo_push),
        .cmd  (push_cmd)
    );

    klb_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fifo_push),
        .push_cmd (push_cmd),
        .pop      (fifo_pop),
        .head_cmd (head_cmd),
        .full     (fifo_full),
        .empty    (fifo_empty)
    );

    klb_back #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (head_cmd),
        .empty      (fifo_empty),
        .pop        (fifo_pop),
        .fill_count (fill_count),
        .rsp        (rsp)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        fill_count <= CW'(BUF_DEPTH))
        else $error("fill count beyond buffer depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        fifo_push |-> !fifo_full)
        else $error("command queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.result_kind == KIND_NONE) |-> (rsp.last && rsp.data_char == 8'd0))
        else $error("empty-end result not final");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.dropped)
            |-> (rsp.result_kind == KIND_ECHO && fill_count == CW'(BUF_DEPTH)))
        else $error("drop flagged without a full buffer");

endmodule

FILE: hdl/klb_front.sv
`timescale 1ns / 1ps

module klb_front (
    klb_req_if.sink        req,
    input  logic           full,
    output logic           push,
    output klb_pkg::cmd_t  cmd
);
    import klb_pkg::*;

    logic [7:0] mapped;
    logic       in_range;

    assign req.ready = !full;

    always_comb
    begin
        mapped        = key_lookup(req.scancode[KEY_W-1:0]);
        in_range      = (32'(req.scancode) < MAP_SIZE);
        cmd.op        = req.mode;
        cmd.ch        = (req.mode == CMD_READ) ? req.delimiter : mapped;
        cmd.max_count = req.max_count;
        // drop high and unmapped scancodes here
        if (req.mode == CMD_READ)
        begin
            push = req.valid && !full;
        end
        else
        begin
            push = req.valid && !full && in_range && (mapped != 8'd0);
        end
    end

endmodule

FILE: hdl/klb_cmd_fifo.sv
`timescale 1ns / 1ps

module klb_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  klb_pkg::cmd_t  push_cmd,
    input  logic           pop,
    output klb_pkg::cmd_t  head_cmd,
    output logic           full,
    output logic           empty
);
    import klb_pkg::*;

    localparam int PW   = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
    localparam int CNTW = $clog2(CMD_FIFO_DEPTH + 1);

    cmd_t            slot_reg [CMD_FIFO_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            do_push, do_pop;

    assign full     = (cnt_reg == CNTW'(CMD_FIFO_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign head_cmd = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: hdl/klb_back.sv
`timescale 1ns / 1ps

module klb_back #(
    parameter int BUF_DEPTH = klb_pkg::BUF_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  klb_pkg::cmd_t                  cmd,
    input  logic                           empty,
    output logic                           pop,
    output logic [$clog2(BUF_DEPTH+1)-1:0] fill_count,
    klb_rsp_if.source                      rsp
);
    import klb_pkg::*;

    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int CW = $clog2(BUF_DEPTH + 1);
    localparam int SW = (CW > 7) ? CW : 7;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SCAN     = 3'd1;
    localparam logic [2:0] ST_MISS     = 3'd2;
    localparam logic [2:0] ST_EMIT_RD  = 3'd3;
    localparam logic [2:0] ST_EMIT_OUT = 3'd4;
    localparam logic [2:0] ST_NL_RD    = 3'd5;
    localparam logic [2:0] ST_NL_CHK   = 3'd6;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [AW:0] sum;
        sum = (AW+1)'(base) + (AW+1)'(off);
        if (sum >= (AW+1)'(BUF_DEPTH))
        begin
            sum = sum - (AW+1)'(BUF_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    logic [7:0]    line_mem [BUF_DEPTH];
    logic [7:0]    rd_data_reg;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          rd_vld_reg, rd_vld_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic [CW-1:0] size_reg, size_next;
    logic [7:0]    delim_reg, delim_next;
    logic [6:0]    maxc_reg, maxc_next;
    logic          rsp_vld_reg, rsp_vld_next;
    result_t       rsp_reg, rsp_next;

    logic          out_free;
    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [7:0]    wr_data;
    logic [CW-1:0] found_size;
    logic [CW-1:0] drop_cnt;

    assign out_free        = !rsp_vld_reg || rsp.ready;
    assign fill_count      = count_reg;
    assign rsp.valid       = rsp_vld_reg;
    assign rsp.result_kind = rsp_reg.kind;
    assign rsp.data_char   = rsp_reg.data_char;
    assign rsp.dropped     = rsp_reg.dropped;
    assign rsp.last        = rsp_reg.last;

    always_comb
    begin
        if (SW'(rd_idx_reg) > SW'(maxc_reg))
        begin
            found_size = CW'(maxc_reg);
        end
        else
        begin
            found_size = rd_idx_reg;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        rd_vld_next  = 1'b0;
        rd_idx_next  = rd_idx_reg;
        size_next    = size_reg;
        delim_next   = delim_reg;
        maxc_next    = maxc_reg;
        rsp_vld_next = rsp_vld_reg && !rsp.ready;
        rsp_next     = rsp_reg;
        pop          = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = head_reg;
        wr_en        = 1'b0;
        wr_addr      = wrap_add(head_reg, count_reg);
        wr_data      = cmd.ch;
        drop_cnt     = size_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    if (cmd.op == CMD_READ)
                    begin
                        pop        = 1'b1;
                        delim_next = cmd.ch;
                        maxc_next  = cmd.max_count;
                        idx_next   = '0;
                        state_next = ST_SCAN;
                    end
                    else if (out_free)
                    begin
                        pop          = 1'b1;
                        rsp_vld_next = 1'b1;
                        rsp_next     = '{kind: KIND_ECHO, data_char: cmd.ch,
                                         dropped: 1'b0, last: 1'b1};
                        priority if (cmd.ch == CH_BACKSPACE && count_reg != '0)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                        else if (count_reg != CW'(BUF_DEPTH))
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            rsp_next.dropped = 1'b1;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                priority if (rd_vld_reg && rd_data_reg == delim_reg)
                begin
                    size_next  = found_size;
                    idx_next   = '0;
                    state_next = (found_size == '0) ? ST_NL_RD : ST_EMIT_RD;
                end
                else if (idx_reg == count_reg)
                begin
                    state_next = ST_MISS;
                end
                else
                begin
                    rd_en       = 1'b1;
                    rd_addr     = wrap_add(head_reg, idx_reg);
                    rd_vld_next = 1'b1;
                    rd_idx_next = idx_reg;
                    idx_next    = idx_reg + 1'b1;
                end
            end

            ST_MISS:
            begin
                if (out_free)
                begin
                    rsp_vld_next = 1'b1;
                    rsp_next     = '{kind: KIND_NONE, data_char: 8'd0,
                                     dropped: 1'b0, last: 1'b1};
                    state_next   = ST_IDLE;
                end
            end

            ST_EMIT_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = wrap_add(head_reg, idx_reg);
                state_next = ST_EMIT_OUT;
            end

            ST_EMIT_OUT:
            begin
                if (out_free)
                begin
                    rsp_vld_next = 1'b1;
                    rsp_next     = '{kind: KIND_DATA, data_char: rd_data_reg, dropped: 1'b0,
                                     last: (idx_reg + 1'b1 == size_reg)};
                    idx_next     = idx_reg + 1'b1;
                    state_next   = (idx_reg + 1'b1 == size_reg) ? ST_NL_RD : ST_EMIT_RD;
                end
            end

            ST_NL_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = wrap_add(head_reg, size_reg);
                state_next = ST_NL_CHK;
            end

            ST_NL_CHK:
            begin
                if (size_reg != '0 || out_free)
                begin
                    drop_cnt   = size_reg + CW'(rd_data_reg == CH_NEWLINE);
                    head_next  = wrap_add(head_reg, drop_cnt);
                    count_next = count_reg - drop_cnt;
                    state_next = ST_IDLE;
                    if (size_reg == '0)
                    begin
                        rsp_vld_next = 1'b1;
                        rsp_next     = '{kind: KIND_NONE, data_char: 8'd0,
                                         dropped: 1'b0, last: 1'b1};
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            idx_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            rd_vld_reg  <= rd_vld_next;
            rsp_vld_reg <= rsp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_idx_next;
        size_reg   <= size_next;
        delim_reg  <= delim_next;
        maxc_reg   <= maxc_next;
        rsp_reg    <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= line_mem[rd_addr];
        end
    end

endmodule

FILE: bench/tb_keyboard_line_buffer.sv
`timescale 1ns / 1ps

module tb_keyboard_line_buffer;
    import klb_pkg::*;

    localparam int LINE_DEPTH  = BUF_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 400;
    localparam int PHASE_ITEMS = 145;
    localparam int DIR_ROWS    = 23;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_QUIET,
        CHK_TYPED
    } chk_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] sc;
        logic [7:0] dl;
        logic [6:0] mc;
        chk_t       how;
        result_t    want;
    } stim_row_t;

    localparam result_t NO_RSP   = '0;
    localparam result_t NONE_RSP = '{KIND_NONE, 8'h00, 1'b0, 1'b1};

    logic clk;
    logic rst_n;

    klb_req_if req_if ();
    klb_rsp_if rsp_if ();

    keyboard_line_buffer u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    logic [7:0] layout_code [46] = '{
        8'd2,  8'd3,  8'd4,  8'd5,  8'd6,  8'd7,  8'd8,  8'd9,  8'd10, 8'd11, 8'd14, 8'd15,
        8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 8'd21, 8'd22, 8'd23, 8'd24, 8'd25, 8'd27, 8'd28,
        8'd30, 8'd31, 8'd32, 8'd33, 8'd34, 8'd35, 8'd36, 8'd37, 8'd38, 8'd43, 8'd86,
        8'd44, 8'd45, 8'd46, 8'd47, 8'd48, 8'd49, 8'd50, 8'd51, 8'd52, 8'd53, 8'd57
    };
    logic [7:0] layout_char [46] = '{
        "1", "2", "3", "4", "5", "&", "/", "8", "9", "0", CH_BACKSPACE, CH_TAB,
        "q", "w", "e", "r", "t", "z", "u", "i", "o", "p", "*", CH_NEWLINE,
        "a", "s", "d", "f", "g", "h", "j", "k", "l", "#", "<",
        "y", "x", "c", "v", "b", "n", "m", ",", ".", "-", " "
    };

    stim_row_t dir_tab [DIR_ROWS] = '{
        '{CMD_READ, 8'hFF, CH_NEWLINE, 7'd64, CHK_TYPED, NONE_RSP},
        '{CMD_CHAR, 8'hFF, 8'hA5, 7'd33, CHK_QUIET, NO_RSP},
        '{CMD_CHAR, 8'h80, 8'h5A, 7'd64, CHK_QUIET, NO_RSP},
        '{CMD_CHAR, 8'h00, 8'hFF, 7'd63, CHK_QUIET, NO_RSP},
        '{CMD_CHAR, 8'h7F, 8'h00, 7'd0, CHK_QUIET, NO_RSP},
        '{CMD_CHAR, 8'd14, 8'h00, 7'd0, CHK_TYPED, '{KIND_ECHO, CH_BACKSPACE, 1'b0, 1'b1}},
        '{CMD_CHAR, 8'd14, 8'hFF, 7'd63, CHK_TYPED, '{KIND_ECHO, CH_BACKSPACE, 1'b0, 1'b1}},
        '{CMD_CHAR, 8'd2, 8'h31, 7'd1, CHK_TYPED, '{KIND_ECHO, 8'h31, 1'b0, 1'b1}},
        '{CMD_CHAR, 8'd16, 8'h0A, 7'd2, CHK_TYPED, '{KIND_ECHO, 8'h71, 1'b0, 1'b1}},
        '{CMD_CHAR, 8'd57, 8'h20, 7'd3, CHK_TYPED, '{KIND_ECHO, 8'h20, 1'b0, 1'b1}},
        '{CMD_CHAR, 8'd86, 8'h3C, 7'd4, CHK_TYPED, '{KIND_ECHO, 8'h3C, 1'b0, 1'b1}},
        '{CMD_CHAR, 8'd28, 8'h0A, 7'd5, CHK_TYPED, '{KIND_ECHO, CH_NEWLINE, 1'b0, 1'b1}},
        '{CMD_READ, 8'h00, CH_NEWLINE, 7'd0, CHK_TYPED, NONE_RSP},
        '{CMD_READ, 8'h7F, 8'h31, 7'd64, CHK_TYPED, NONE_RSP},
        '{CMD_READ, 8'h80, 8'hFF, 7'd5, CHK_TYPED, NONE_RSP},
        '{CMD_READ, 8'h55, CH_NEWLINE, 7'd2, CHK_MODEL, NO_RSP},
        '{CMD_READ, 8'hAA, CH_NEWLINE, 7'd64, CHK_MODEL, NO_RSP},
        '{CMD_CHAR, 8'd15, 8'h09, 7'd7, CHK_TYPED, '{KIND_ECHO, CH_TAB, 1'b0, 1'b1}},
        '{CMD_CHAR, 8'd28, 8'h11, 7'd8, CHK_TYPED, '{KIND_ECHO, CH_NEWLINE, 1'b0, 1'b1}},
        '{CMD_CHAR, 8'd28, 8'h22, 7'd9, CHK_TYPED, '{KIND_ECHO, CH_NEWLINE, 1'b0, 1'b1}},
        '{CMD_READ, 8'h01, CH_NEWLINE, 7'd64, CHK_MODEL, NO_RSP},
        '{CMD_READ, 8'hFE, CH_NEWLINE, 7'd1, CHK_TYPED, NONE_RSP},
        '{CMD_READ, 8'h3C, 8'h00, 7'd64, CHK_TYPED, NONE_RSP}
    };

    logic [7:0] keymap [MAP_SIZE];
    logic [7:0] line_q [$];
    result_t    step_rsp [$];
    result_t    pending_rsp [$];

    int  send_idle;
    int  recv_idle;
    int  err_cnt;
    int  cycle_cnt;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("keyboard_line_buffer regression: fail");
            $finish;
        end
    end

    task automatic note_err(input string msg);
        err_cnt++;
        if (err_cnt <= 10)
            $display("%s", msg);
    endtask

    task automatic kbd_apply(input logic m, input logic [7:0] sc, input logic [7:0] dl,
                             input logic [6:0] mc);
        logic [7:0] ch;
        logic       drop;
        int         idx;
        int         cnt;
        int         i;
        step_rsp.delete();
        if (m == CMD_CHAR)
        begin
            if (sc[7])
                return;
            ch = keymap[sc[6:0]];
            if (ch == 8'd0)
                return;
            drop = 1'b0;
            if (ch == CH_BACKSPACE && line_q.size() > 0)
                void'(line_q.pop_back());
            else if (line_q.size() < LINE_DEPTH)
                line_q.push_back(ch);
            else
                drop = 1'b1;
            step_rsp.push_back(result_t'{KIND_ECHO, ch, drop, 1'b1});
        end
        else
        begin
            idx = -1;
            for (i = 0; i < line_q.size(); i++)
                if (idx < 0 && line_q[i] == dl)
                    idx = i;
            if (idx < 0)
            begin
                step_rsp.push_back(NONE_RSP);
                return;
            end
            cnt = (idx > int'(mc)) ? int'(mc) : idx;
            for (i = 0; i < cnt; i++)
                step_rsp.push_back(result_t'{KIND_DATA, line_q[i], 1'b0, i == cnt - 1});
            repeat (cnt) void'(line_q.pop_front());
            if (line_q.size() > 0 && line_q[0] == CH_NEWLINE)
                void'(line_q.pop_front());
            if (cnt == 0)
                step_rsp.push_back(NONE_RSP);
        end
    endtask

    task automatic send_req(input logic m, input logic [7:0] sc, input logic [7:0] dl,
                            input logic [6:0] mc, input chk_t how, input result_t want,
                            output int nres);
        bit taken;
        while ($urandom_range(0, 99) < send_idle)
        begin
            req_if.valid = 1'b0;
            @(negedge clk);
        end
        req_if.valid     = 1'b1;
        req_if.mode      = m;
        req_if.scancode  = sc;
        req_if.delimiter = dl;
        req_if.max_count = mc;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = req_if.ready;
        end
        kbd_apply(m, sc, dl, mc);
        nres = step_rsp.size();
        if (how == CHK_MODEL)
            foreach (step_rsp[k])
                pending_rsp.push_back(step_rsp[k]);
        else if (how == CHK_TYPED)
            pending_rsp.push_back(want);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_if.valid = 1'b0;
        while (pending_rsp.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] text_code();
        logic [7:0] c;
        do
            c = layout_code[$urandom_range(0, 45)];
        while (keymap[c[6:0]] == CH_BACKSPACE || keymap[c[6:0]] == CH_NEWLINE);
        return c;
    endfunction

    function automatic logic [6:0] rand_count();
        if ($urandom_range(0, 3) == 0)
            return 7'd64;
        return 7'($urandom_range(0, 64));
    endfunction

    task automatic type_key(input logic [7:0] sc, inout int items);
        int n;
        send_req(CMD_CHAR, sc, 8'($urandom), 7'($urandom_range(0, 64)), CHK_MODEL, NO_RSP, n);
        if (n > 0)
            items++;
    endtask

    task automatic read_line(input logic [7:0] dl, input logic [6:0] mc, inout int items);
        int n;
        send_req(CMD_READ, 8'($urandom), dl, mc, CHK_MODEL, NO_RSP, n);
        items++;
    endtask

    task automatic run_phase(input bit flood_first);
        int items;
        int pick;
        int len;
        int j;
        items = 0;
        while (items < PHASE_ITEMS)
        begin
            pick = flood_first ? 92 : $urandom_range(0, 99);
            flood_first = 1'b0;
            if (pick < 60)
            begin
                len = $urandom_range(1, 12);
                for (j = 0; j < len; j++)
                    type_key(($urandom_range(0, 9) == 0) ? 8'd14 : text_code(), items);
                type_key(8'd28, items);
                if ($urandom_range(0, 9) < 7)
                    read_line(($urandom_range(0, 4) != 0) ? CH_NEWLINE
                              : keymap[7'(text_code())], rand_count(), items);
            end
            else if (pick < 75)
            begin
                if (line_q.size() > 0 && $urandom_range(0, 1) == 1)
                    read_line(line_q[$urandom_range(0, line_q.size() - 1)],
                              rand_count(), items);
                else
                    read_line(8'($urandom), rand_count(), items);
            end
            else if (pick < 90)
            begin
                type_key(8'($urandom), items);
            end
            else if (pick < 95)
            begin
                len = LINE_DEPTH - line_q.size() + $urandom_range(1, 3);
                for (j = 0; j < len; j++)
                    type_key(($urandom_range(0, 7) == 0) ? 8'd28 : text_code(), items);
                if ($urandom_range(0, 1) == 1)
                    type_key(8'd14, items);
                len = $urandom_range(2, 6);
                for (j = 0; j < len; j++)
                    read_line(CH_NEWLINE, 7'd64, items);
            end
            else
            begin
                wait_drained();
            end
        end
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        result_t got;
        result_t exp_r;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got = '{rsp_if.result_kind, rsp_if.data_char, rsp_if.dropped, rsp_if.last};
            if (pending_rsp.size() == 0)
                note_err($sformatf("unexpected transaction kind=%0d char=%02h drop=%0b last=%0b",
                                   got.kind, got.data_char, got.dropped, got.last));
            else
            begin
                exp_r = pending_rsp.pop_front();
                if (got.kind != exp_r.kind || got.data_char != exp_r.data_char
                    || got.dropped != exp_r.dropped || got.last != exp_r.last)
                    note_err($sformatf({"mismatch: expected kind=%0d char=%02h drop=%0b last=%0b",
                                        " got kind=%0d char=%02h drop=%0b last=%0b"},
                                       exp_r.kind, exp_r.data_char, exp_r.dropped, exp_r.last,
                                       got.kind, got.data_char, got.dropped, got.last));
            end
        end
    end

    initial
    begin
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_if.ready = ($urandom_range(0, 99) >= recv_idle);
        end
    end

    initial
    begin
        int n;
        int r;
        req_if.valid     = 1'b0;
        req_if.mode      = CMD_CHAR;
        req_if.scancode  = 8'h00;
        req_if.delimiter = 8'h00;
        req_if.max_count = 7'd0;
        rst_n            = 1'b0;
        err_cnt          = 0;
        cycle_cnt        = 0;
        send_idle        = 20;
        recv_idle        = 61;
        for (r = 0; r < MAP_SIZE; r++)
            keymap[r] = 8'h00;
        for (r = 0; r < 46; r++)
            keymap[layout_code[r][6:0]] = layout_char[r];
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (r = 0; r < DIR_ROWS; r++)
            send_req(dir_tab[r].mode, dir_tab[r].sc, dir_tab[r].dl, dir_tab[r].mc,
                     dir_tab[r].how, dir_tab[r].want, n);
        wait_drained();

        run_phase(1'b1);
        send_idle = 61;
        recv_idle = 20;
        run_phase(1'b0);
        send_idle = 0;
        recv_idle = 0;
        run_phase(1'b0);

        repeat (TAIL_CYCLES) @(negedge clk);
        if (err_cnt == 0 && pending_rsp.size() == 0)
            $display("keyboard_line_buffer regression: pass");
        else
            $display("keyboard_line_buffer regression: fail");
        $finish;
    end

endmodule
